@@ hdl/tmtb_pkg.sv @@
// Shared constants, register codes and band tables for the texel blend pipeline.
// No dependencies; every other file imports this package.
package tmtb_pkg;

  // Register codes, indexed by paddr[4:2]
  localparam logic [2:0] REG_LUMA_GAIN    = 3'd0;
  localparam logic [2:0] REG_LUMA_OFFSET  = 3'd1;
  localparam logic [2:0] REG_CHROMA_SCALE = 3'd2;
  localparam logic [2:0] REG_SHIFT_RED    = 3'd3;
  localparam logic [2:0] REG_SHIFT_GREEN  = 3'd4;
  localparam logic [2:0] REG_SHIFT_BLUE   = 3'd5;
  localparam logic [2:0] REG_BAND_CELLS   = 3'd6;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned NUM_STAGES = 7;

  // Rec.709 luma weights in Q0.16, summing to 1.0
  localparam logic [15:0] LUMA_COEF_R = 16'd13933;
  localparam logic [15:0] LUMA_COEF_G = 16'd46871;
  localparam logic [15:0] LUMA_COEF_B = 16'd4732;

  localparam int unsigned WEIGHT_W   = 17;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;
  localparam int unsigned QUOT_W     = 26;
  localparam int unsigned RECIP_W    = 27;
  localparam int unsigned RSHIFT_W   = 6;
  localparam int unsigned CUBE_W     = 10;

  // Cube of the band width in cells, index is band - 1
  function automatic logic [CUBE_W-1:0] band_cube(input logic [2:0] idx);
    logic [CUBE_W-1:0] c;
    case (idx)
      3'd0:    c = 10'd1;
      3'd1:    c = 10'd8;
      3'd2:    c = 10'd27;
      3'd3:    c = 10'd64;
      3'd4:    c = 10'd125;
      3'd5:    c = 10'd216;
      3'd6:    c = 10'd343;
      default: c = 10'd512;
    endcase
    return c;
  endfunction

  // ceil(2^s / cube): exact floor division for 26-bit numerators
  function automatic logic [RECIP_W-1:0] band_recip(input logic [2:0] idx);
    logic [RECIP_W-1:0] m;
    case (idx)
      3'd0:    m = 27'd67108864;
      3'd1:    m = 27'd67108864;
      3'd2:    m = 27'd79536432;
      3'd3:    m = 27'd67108864;
      3'd4:    m = 27'd68719477;
      3'd5:    m = 27'd79536432;
      3'd6:    m = 27'd100174165;
      default: m = 27'd67108864;
    endcase
    return m;
  endfunction

  function automatic logic [RSHIFT_W-1:0] band_shift(input logic [2:0] idx);
    logic [RSHIFT_W-1:0] s;
    case (idx)
      3'd0:    s = 6'd26;
      3'd1:    s = 6'd29;
      3'd2:    s = 6'd31;
      3'd3:    s = 6'd32;
      3'd4:    s = 6'd33;
      3'd5:    s = 6'd34;
      3'd6:    s = 6'd35;
      default: s = 6'd35;
    endcase
    return s;
  endfunction

endpackage

@@ hdl/tone_matched_texel_blend.sv @@
// Top level of the texel blend: APB register file, pipeline control and output stage.
// Depends on tmtb_pkg, tmtb_weight, tmtb_tone and tmtb_blend.
//
// Usage: one texel per transfer on the input channel (in_valid_i / in_stall_o),
// one result per texel on the output channel (out_valid_o / out_stall_i).
// The datapath is seven register stages; a texel accepted on the input passes
// through all seven before it is presented on out_valid_o. Throughput is one
// texel per clock while the receiver does not stall; the slowest stage is a
// single multiplier (16x16, 32x17, 26x27, 26x18) per stage, in both the
// smoothstep divide and the channel blend.
// When the receiver stalls, the output register holds and empty stages
// further up still fill, so in_stall_o rises only once all seven stages hold
// a texel. No item is dropped or repeated.
// Reset (rst_ni low) empties the pipeline and returns all registers to
// gain 1.0, offset 0, saturation 1.0, shifts 0 and a band of one cell.
// Registers sit at byte offsets 4*i on the APB port; the user must see that they are
// written only while no texel is in flight, as the block does not enforce this.
module tone_matched_texel_blend import tmtb_pkg::*; #(
  parameter int unsigned REF_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [31:0]           colour_in_i,
  input  logic [REF_BITS-1:0]   ref_red_i,
  input  logic [REF_BITS-1:0]   ref_green_i,
  input  logic [REF_BITS-1:0]   ref_blue_i,
  input  logic                  ref_valid_i,
  input  logic                  cell_painted_i,
  input  logic [15:0]           distance_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [31:0]           colour_out_o,
  output logic                  filled_o,
  output logic                  no_reference_o,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [15:0] luma_gain_q, luma_offset_q, chroma_scale_q;
  logic [15:0] shift_red_q, shift_green_q, shift_blue_q;
  logic [3:0]  band_cells_q;
  logic [2:0]  reg_idx;
  logic        cfg_write;
  logic [3:0]  band_m1;
  logic [2:0]  band_idx;

  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES:0]   rdy;
  logic [NUM_STAGES-1:0] adv;

  logic [5:0][31:0] col_q;
  logic [5:0]       fill_q, nref_q;
  logic             active_d;

  logic [31:0] colour_out_d, colour_out_q;
  logic        filled_q, no_ref_q;

  logic [WEIGHT_W-1:0]      weight;
  logic [2:0][WEIGHT_W-1:0] tone;
  logic [23:0]              blended;

  // APB register file
  assign pready    = 1'b1;
  assign reg_idx   = paddr[4:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      luma_gain_q    <= 16'd32768;
      luma_offset_q  <= 16'd0;
      chroma_scale_q <= 16'd8192;
      shift_red_q    <= 16'd0;
      shift_green_q  <= 16'd0;
      shift_blue_q   <= 16'd0;
      band_cells_q   <= 4'd1;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_LUMA_GAIN:    luma_gain_q    <= pwdata[15:0];
        REG_LUMA_OFFSET:  luma_offset_q  <= pwdata[15:0];
        REG_CHROMA_SCALE: chroma_scale_q <= pwdata[15:0];
        REG_SHIFT_RED:    shift_red_q    <= pwdata[15:0];
        REG_SHIFT_GREEN:  shift_green_q  <= pwdata[15:0];
        REG_SHIFT_BLUE:   shift_blue_q   <= pwdata[15:0];
        REG_BAND_CELLS:   band_cells_q   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LUMA_GAIN:    prdata = {16'd0, luma_gain_q};
      REG_LUMA_OFFSET:  prdata = {16'd0, luma_offset_q};
      REG_CHROMA_SCALE: prdata = {16'd0, chroma_scale_q};
      REG_SHIFT_RED:    prdata = {16'd0, shift_red_q};
      REG_SHIFT_GREEN:  prdata = {16'd0, shift_green_q};
      REG_SHIFT_BLUE:   prdata = {16'd0, shift_blue_q};
      REG_BAND_CELLS:   prdata = {28'd0, band_cells_q};
      default:          prdata = 32'd0;
    endcase
  end

  // Treat a band of zero as one cell and anything above eight as eight
  always_comb begin
    band_m1 = band_cells_q - 4'd1;
    if (band_cells_q == 4'd0) begin
      band_idx = 3'd0;
    end else if (band_cells_q > 4'd8) begin
      band_idx = 3'd7;
    end else begin
      band_idx = band_m1[2:0];
    end
  end

  // Pipeline control: a stage loads when it is empty or its successor loads
  always_comb begin
    rdy[NUM_STAGES] = !out_stall_i;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    adv = rdy[NUM_STAGES-1:0];
  end

  assign in_stall_o = !rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Painted cells and zero distance pass through; a missing reference is flagged
  assign active_d = !cell_painted_i && (distance_i != 16'd0);

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      col_q[0]  <= colour_in_i;
      fill_q[0] <= active_d && ref_valid_i;
      nref_q[0] <= active_d && !ref_valid_i;
    end
    for (int k = 1; k < 6; k++) begin
      if (adv[k]) begin
        col_q[k]  <= col_q[k-1];
        fill_q[k] <= fill_q[k-1];
        nref_q[k] <= nref_q[k-1];
      end
    end
    if (adv[6]) begin
      colour_out_q <= colour_out_d;
      filled_q     <= fill_q[5];
      no_ref_q     <= nref_q[5];
    end
  end

  assign colour_out_d = fill_q[5] ? {col_q[5][31:24], blended} : col_q[5];

  tmtb_weight u_weight (
    .clk_i      (clk_i),
    .adv_i      (adv[4:0]),
    .distance_i (distance_i),
    .band_idx_i (band_idx),
    .weight_o   (weight)
  );

  tmtb_tone #(
    .REF_BITS (REF_BITS)
  ) u_tone (
    .clk_i          (clk_i),
    .adv_i          (adv[2:0]),
    .ref_i          ({ref_red_i, ref_green_i, ref_blue_i}),
    .luma_gain_i    (luma_gain_q),
    .luma_offset_i  (luma_offset_q),
    .chroma_scale_i (chroma_scale_q),
    .chroma_shift_i ({shift_red_q, shift_green_q, shift_blue_q}),
    .tone_o         (tone)
  );

  tmtb_blend u_blend (
    .clk_i    (clk_i),
    .adv_i    (adv[5:3]),
    .tone_i   (tone),
    .colour_i (col_q[2][23:0]),
    .weight_i (weight),
    .colour_o (blended)
  );

  assign out_valid_o    = vld_q[6];
  assign colour_out_o   = colour_out_q;
  assign filled_o       = filled_q;
  assign no_reference_o = no_ref_q;

  // A stalled input means every stage holds a texel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q))
    else $error("input stalled while the pipeline has an empty stage");

  // Blended and missing-reference are exclusive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(filled_o && no_reference_o))
    else $error("result flagged both filled and missing reference");

  // The weight never exceeds 1.0 when a texel reaches the blend multiplier
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[4] |-> (weight <= WEIGHT_ONE))
    else $error("weight above 1.0");

  // A result taken with nothing behind it leaves the output empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[6] && !out_stall_i && !vld_q[5]) |=> !out_valid_o)
    else $error("result repeated after transfer");

endmodule

@@ hdl/tmtb_weight.sv @@
// Five-stage smoothstep weight unit: d*d*(3D-2d)/D^3 rounded to Q0.16.
// Depends on tmtb_pkg for the band cube and reciprocal tables.
module tmtb_weight import tmtb_pkg::*; (
  input  logic                clk_i,
  input  logic [4:0]          adv_i,
  input  logic [15:0]         distance_i,
  input  logic [2:0]          band_idx_i,
  output logic [WEIGHT_W-1:0] weight_o
);

  logic [3:0]          span_cells;
  logic [15:0]         span;
  logic [17:0]         cubic_k;
  logic [31:0]         d2_d, d2_q;
  logic [16:0]         k_d, k_q;
  logic [48:0]         p_d, p_q;
  logic [49:0]         p_sum;
  logic [QUOT_W-1:0]   n_d, n_q;
  logic [52:0]         q_d, q_q;
  logic [52:0]         q_shifted;
  logic [WEIGHT_W-1:0] w_d, w_q;
  logic [3:0]          full_q;
  logic                full_d;

  always_comb begin
    span_cells = {1'b0, band_idx_i} + 4'd1;
    span       = {span_cells, 12'd0};
    full_d     = distance_i >= span;
    cubic_k    = {2'b00, span} + {1'b0, span, 1'b0} - {1'b0, distance_i, 1'b0};
    k_d        = cubic_k[16:0];
    d2_d       = 32'(distance_i) * 32'(distance_i);
    p_d        = 49'(d2_q) * 49'(k_q);
    // add half of the divisor, drop the power-of-two part, then divide by the cube
    p_sum      = 50'(p_q) + (50'(band_cube(band_idx_i)) << 19);
    n_d        = p_sum[45:20];
    q_d        = 53'(n_q) * 53'(band_recip(band_idx_i));
    q_shifted  = q_q >> band_shift(band_idx_i);
    w_d        = full_q[3] ? WEIGHT_ONE : q_shifted[WEIGHT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      d2_q      <= d2_d;
      k_q       <= k_d;
      full_q[0] <= full_d;
    end
    if (adv_i[1]) begin
      p_q       <= p_d;
      full_q[1] <= full_q[0];
    end
    if (adv_i[2]) begin
      n_q       <= n_d;
      full_q[2] <= full_q[1];
    end
    if (adv_i[3]) begin
      q_q       <= q_d;
      full_q[3] <= full_q[2];
    end
    if (adv_i[4]) begin
      w_q <= w_d;
    end
  end

  assign weight_o = w_q;

endmodule

@@ hdl/tmtb_tone.sv @@
// Three-stage tone match: luma, gain and chroma products, sum with clamp to Q0.16.
// Depends on tmtb_pkg for the luma weights.
module tmtb_tone import tmtb_pkg::*; #(
  parameter int unsigned REF_BITS = 12
) (
  input  logic                     clk_i,
  input  logic [2:0]               adv_i,
  input  logic [2:0][REF_BITS-1:0] ref_i,
  input  logic [15:0]              luma_gain_i,
  input  logic [15:0]              luma_offset_i,
  input  logic [15:0]              chroma_scale_i,
  input  logic [2:0][15:0]         chroma_shift_i,
  output logic [2:0][WEIGHT_W-1:0] tone_o
);

  localparam int unsigned LUMA_W    = REF_BITS + 16;
  localparam int unsigned GAIN_W    = REF_BITS + 32;
  localparam int unsigned DIFF_W    = REF_BITS + 17;
  localparam int unsigned CS_W      = REF_BITS + 34;
  localparam int unsigned ACC_W     = REF_BITS + 38;
  localparam int unsigned WORK_FRAC = REF_BITS + 31;
  localparam logic signed [ACC_W-1:0] TONE_ONE   = ACC_W'(1) <<< WORK_FRAC;
  localparam logic signed [ACC_W-1:0] TONE_ROUND = ACC_W'(1) <<< (WORK_FRAC - 17);

  logic [LUMA_W-1:0]               luma_d, luma_q;
  logic [2:0][REF_BITS-1:0]        ref_q;
  logic [GAIN_W-1:0]               gl_d, gl_q;
  logic signed [16:0]              scale_s;
  logic signed [DIFF_W-1:0]        cdiff [3];
  logic signed [CS_W-1:0]          cs_d [3], cs_q [3];
  logic signed [ACC_W-1:0]         acc [3], acc_clamped [3], acc_rnd [3];
  logic signed [ACC_W-1:0]         gl_s;
  logic [2:0][WEIGHT_W-1:0]        tone_d, tone_q;

  always_comb begin
    luma_d = LUMA_W'(ref_i[2]) * LUMA_W'(LUMA_COEF_R)
           + LUMA_W'(ref_i[1]) * LUMA_W'(LUMA_COEF_G)
           + LUMA_W'(ref_i[0]) * LUMA_W'(LUMA_COEF_B);
    gl_d    = GAIN_W'(luma_gain_i) * GAIN_W'(luma_q);
    scale_s = $signed({1'b0, chroma_scale_i});
    gl_s    = ACC_W'($signed({1'b0, gl_q}));
    for (int k = 0; k < 3; k++) begin
      cdiff[k] = $signed({1'b0, ref_q[k], 16'd0}) - $signed({1'b0, luma_q});
      cs_d[k]  = CS_W'(scale_s) * CS_W'(cdiff[k]);
      acc[k]   = gl_s + (ACC_W'(cs_q[k]) <<< 2)
               + ((ACC_W'($signed(luma_offset_i)) + ACC_W'($signed(chroma_shift_i[k])))
                  <<< LUMA_W);
      if (acc[k] < 0) begin
        acc_clamped[k] = '0;
      end else if (acc[k] > TONE_ONE) begin
        acc_clamped[k] = TONE_ONE;
      end else begin
        acc_clamped[k] = acc[k];
      end
      acc_rnd[k] = acc_clamped[k] + TONE_ROUND;
      tone_d[k]  = acc_rnd[k][WORK_FRAC:WORK_FRAC-16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      luma_q <= luma_d;
      ref_q  <= ref_i;
    end
    if (adv_i[1]) begin
      gl_q <= gl_d;
      cs_q <= cs_d;
    end
    if (adv_i[2]) begin
      tone_q <= tone_d;
    end
  end

  assign tone_o = tone_q;

endmodule

@@ hdl/tmtb_blend.sv @@
// Three-stage channel blend: c + (T - c) * w with half-up rounding to a byte.
// Depends on tmtb_pkg for the weight width.
module tmtb_blend import tmtb_pkg::*; (
  input  logic                     clk_i,
  input  logic [2:0]               adv_i,
  input  logic [2:0][WEIGHT_W-1:0] tone_i,
  input  logic [23:0]              colour_i,
  input  logic [WEIGHT_W-1:0]      weight_i,
  output logic [23:0]              colour_o
);

  localparam int unsigned DIFF_W = 26;
  localparam int unsigned PROD_W = 44;
  localparam int unsigned X_W    = 45;

  logic [2:0][24:0]               tone_scaled;
  logic signed [DIFF_W-1:0]       diff_d [3], diff3_q [3], diff4_q [3];
  logic signed [PROD_W-1:0]       prod_d [3], prod_q [3];
  logic signed [X_W-1:0]          x [3], x_rnd [3];
  logic [2:0][12:0]               r_wide;
  logic [23:0]                    col3_q, col4_q, col5_q;
  logic signed [17:0]             w_s;

  always_comb begin
    w_s = $signed({1'b0, weight_i});
    for (int k = 0; k < 3; k++) begin
      tone_scaled[k] = 25'(tone_i[k]) * 25'd255;
      diff_d[k] = $signed({1'b0, tone_scaled[k]})
                - $signed({2'b00, colour_i[8*k +: 8], 16'd0});
      prod_d[k] = PROD_W'(diff4_q[k]) * PROD_W'(w_s);
      x[k]      = $signed({5'd0, col5_q[8*k +: 8], 32'd0}) + X_W'(prod_q[k]);
      x_rnd[k]  = x[k] + (X_W'(1) <<< 31);
      r_wide[k] = x_rnd[k][X_W-1:32];
      if (x[k] < 0) begin
        colour_o[8*k +: 8] = 8'd0;
      end else if (r_wide[k] > 13'd255) begin
        colour_o[8*k +: 8] = 8'd255;
      end else begin
        colour_o[8*k +: 8] = r_wide[k][7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      diff3_q <= diff_d;
      col3_q  <= colour_i;
    end
    if (adv_i[1]) begin
      diff4_q <= diff3_q;
      col4_q  <= col3_q;
    end
    if (adv_i[2]) begin
      prod_q <= prod_d;
      col5_q <= col4_q;
    end
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for tone_matched_texel_blend: directed and random texel
// traffic with bursty input, patterned output stall and an in-line tone/blend predictor.
// Depends on tmtb_pkg and the tone_matched_texel_blend RTL.
module tb import tmtb_pkg::*; ();

  localparam int unsigned REF_BITS    = 12;
  localparam int unsigned WORK_FRAC   = REF_BITS + 31;
  localparam int unsigned LUMA_FRAC   = REF_BITS + 16;
  localparam int unsigned PIPE_DRAIN  = 12;
  localparam int unsigned PHASE_ITEMS = 100;
  localparam longint      CYCLE_LIMIT = 400000;

  typedef struct {
    logic [31:0]         colour;
    logic [REF_BITS-1:0] red;
    logic [REF_BITS-1:0] green;
    logic [REF_BITS-1:0] blue;
    logic                ref_valid;
    logic                painted;
    logic [15:0]         distance;
  } texel_t;

  typedef struct {
    logic [31:0] colour;
    logic        filled;
    logic        no_reference;
  } blend_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic [31:0]           colour_in_i    = '0;
  logic [REF_BITS-1:0]   ref_red_i      = '0;
  logic [REF_BITS-1:0]   ref_green_i    = '0;
  logic [REF_BITS-1:0]   ref_blue_i     = '0;
  logic                  ref_valid_i    = 1'b0;
  logic                  cell_painted_i = 1'b0;
  logic [15:0]           distance_i     = '0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [31:0]           colour_out_o;
  logic                  filled_o;
  logic                  no_reference_o;
  logic                  psel           = 1'b0;
  logic                  penable        = 1'b0;
  logic                  pwrite         = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr          = '0;
  logic [31:0]           pwdata         = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // predictor's copy of the register file
  logic [15:0] cfg_gain;
  logic [15:0] cfg_offset;
  logic [15:0] cfg_sat;
  logic [15:0] cfg_shift_red;
  logic [15:0] cfg_shift_green;
  logic [15:0] cfg_shift_blue;
  logic [3:0]  cfg_band;

  texel_t        texel_backlog[$];
  blend_result_t expected_blends[$];
  texel_t        loaded;
  blend_result_t seen;
  blend_result_t want;
  int            burst_left;
  int            gap_left;
  int            stall_mode;
  int            stall_left;
  int            errors;
  longint        cycle_count;

  tone_matched_texel_blend #(.REF_BITS(REF_BITS)) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .colour_in_i    (colour_in_i),
    .ref_red_i      (ref_red_i),
    .ref_green_i    (ref_green_i),
    .ref_blue_i     (ref_blue_i),
    .ref_valid_i    (ref_valid_i),
    .cell_painted_i (cell_painted_i),
    .distance_i     (distance_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .colour_out_o   (colour_out_o),
    .filled_o       (filled_o),
    .no_reference_o (no_reference_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // tone-matched channel in Q0.16, 0..65536
  function automatic longint tone_q16(longint refk, longint luma, longint shiftk);
    longint acc;
    longint one;
    one = 64'sd1 << WORK_FRAC;
    acc = longint'(cfg_gain) * luma;
    acc += longint'($signed(cfg_offset)) * (64'sd1 << LUMA_FRAC);
    acc += longint'(cfg_sat) * (refk * 65536 - luma) * 4;
    acc += shiftk * (64'sd1 << LUMA_FRAC);
    if (acc < 0) acc = 0;
    if (acc > one) acc = one;
    return (acc + (64'sd1 << (WORK_FRAC - 17))) >>> (WORK_FRAC - 16);
  endfunction

  function automatic logic [7:0] mix_channel(longint c, longint t16, longint w16);
    longint x;
    longint r;
    x = c * (64'sd1 << 32) + (255 * t16 - c * 65536) * w16;
    if (x < 0) x = 0;
    r = (x + (64'sd1 << 31)) >>> 32;
    if (r > 255) r = 255;
    return r[7:0];
  endfunction

  function automatic blend_result_t blend_texel(texel_t t);
    blend_result_t res;
    longint band;
    longint span;
    longint d;
    longint w16;
    longint den;
    longint num;
    longint rr;
    longint rg;
    longint rb;
    longint luma;
    res.colour       = t.colour;
    res.filled       = 1'b0;
    res.no_reference = 1'b0;
    d = t.distance;
    if (t.painted || d == 0) return res;
    band = cfg_band;
    if (band == 0) band = 1;
    if (band > 8) band = 8;
    span = band * 4096;
    if (d >= span) begin
      w16 = 65536;
    end else begin
      den = span * span * span;
      num = d * d * (3 * span - 2 * d);
      w16 = (num * 65536 + den / 2) / den;
    end
    if (!t.ref_valid) begin
      res.no_reference = 1'b1;
      return res;
    end
    rr = t.red;
    rg = t.green;
    rb = t.blue;
    luma = longint'(LUMA_COEF_R) * rr + longint'(LUMA_COEF_G) * rg
         + longint'(LUMA_COEF_B) * rb;
    res.colour[23:16] = mix_channel(t.colour[23:16],
                                    tone_q16(rr, luma, longint'($signed(cfg_shift_red))), w16);
    res.colour[15:8]  = mix_channel(t.colour[15:8],
                                    tone_q16(rg, luma, longint'($signed(cfg_shift_green))), w16);
    res.colour[7:0]   = mix_channel(t.colour[7:0],
                                    tone_q16(rb, luma, longint'($signed(cfg_shift_blue))), w16);
    res.filled = 1'b1;
    return res;
  endfunction

  function automatic void queue_texel(logic [31:0] colour, int unsigned r, int unsigned g,
                                      int unsigned b, bit rv, bit painted,
                                      int unsigned dist_units);
    texel_t t;
    t.colour    = colour;
    t.red       = r[REF_BITS-1:0];
    t.green     = g[REF_BITS-1:0];
    t.blue      = b[REF_BITS-1:0];
    t.ref_valid = rv;
    t.painted   = painted;
    t.distance  = dist_units[15:0];
    texel_backlog = {texel_backlog, t};
  endfunction

  function automatic void queue_random_texel();
    int unsigned span;
    int unsigned r;
    int unsigned g;
    int unsigned b;
    int unsigned dist_units;
    span = (cfg_band == 0) ? 4096 : (cfg_band > 8) ? 32768 : cfg_band * 4096;
    case ($urandom_range(0, 7))
      0: begin r = 0; g = 0; b = 0; end
      1: begin r = 4095; g = 4095; b = 4095; end
      default: begin
        r = $urandom_range(0, 4095);
        g = $urandom_range(0, 4095);
        b = $urandom_range(0, 4095);
      end
    endcase
    case ($urandom_range(0, 7))
      0: dist_units = $urandom_range(0, 65535);
      1: dist_units = $urandom_range(0, 16);
      2: dist_units = span - 2 + $urandom_range(0, 4);
      3: dist_units = 65535 - $urandom_range(0, 3);
      default: dist_units = $urandom_range(1, span);
    endcase
    queue_texel($urandom(), r, g, b, $urandom_range(0, 7) != 0, $urandom_range(0, 7) == 0,
                dist_units);
  endfunction

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LUMA_GAIN:    cfg_gain        = value[15:0];
      REG_LUMA_OFFSET:  cfg_offset      = value[15:0];
      REG_CHROMA_SCALE: cfg_sat         = value[15:0];
      REG_SHIFT_RED:    cfg_shift_red   = value[15:0];
      REG_SHIFT_GREEN:  cfg_shift_green = value[15:0];
      REG_SHIFT_BLUE:   cfg_shift_blue  = value[15:0];
      REG_BAND_CELLS:   cfg_band        = value[3:0];
      default: ;
    endcase
  endtask

  task automatic cfg_write_all(input logic [31:0] gain, input logic [31:0] offset,
                               input logic [31:0] sat, input logic [31:0] sr,
                               input logic [31:0] sg, input logic [31:0] sb,
                               input logic [31:0] band);
    cfg_write(REG_LUMA_GAIN, gain);
    cfg_write(REG_LUMA_OFFSET, offset);
    cfg_write(REG_CHROMA_SCALE, sat);
    cfg_write(REG_SHIFT_RED, sr);
    cfg_write(REG_SHIFT_GREEN, sg);
    cfg_write(REG_SHIFT_BLUE, sb);
    cfg_write(REG_BAND_CELLS, band);
  endtask

  // hold until every queued texel has gone through and its result is checked
  task automatic wait_idle();
    while (texel_backlog.size() != 0 || in_valid_i || expected_blends.size() != 0)
      @(posedge clk_i);
    repeat (PIPE_DRAIN) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_shift(bit wild);
    return wild ? $urandom() : ($urandom_range(0, 8191) - 4096);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cfg_gain        = 16'd32768;
    cfg_offset      = 16'd0;
    cfg_sat         = 16'd8192;
    cfg_shift_red   = 16'd0;
    cfg_shift_green = 16'd0;
    cfg_shift_blue  = 16'd0;
    cfg_band        = 4'd1;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed texels at the reset settings (band of one cell)
    queue_texel(32'h80402010, 4095, 0, 0, 1'b1, 1'b1, 100);
    queue_texel(32'h11223344, 100, 200, 300, 1'b0, 1'b1, 5000);
    queue_texel(32'hFFFFFFFF, 0, 0, 0, 1'b1, 1'b0, 0);
    queue_texel(32'h00000000, 4095, 4095, 4095, 1'b0, 1'b0, 0);
    queue_texel(32'hA5A5A5A5, 4095, 4095, 4095, 1'b1, 1'b0, 1);
    queue_texel(32'h5A5A5A5A, 0, 0, 0, 1'b0, 1'b0, 1);
    queue_texel(32'h00000000, 4095, 4095, 4095, 1'b1, 1'b0, 2048);
    queue_texel(32'hFFFFFFFF, 0, 0, 0, 1'b1, 1'b0, 4095);
    queue_texel(32'h7F000000, 4095, 0, 0, 1'b1, 1'b0, 4096);
    queue_texel(32'h01FFFFFF, 0, 4095, 0, 1'b1, 1'b0, 4097);
    queue_texel(32'hFE808080, 0, 0, 4095, 1'b1, 1'b0, 65535);
    queue_texel(32'h00FFFFFF, 4095, 4095, 4095, 1'b1, 1'b0, 65535);
    queue_texel(32'hFF000000, 0, 0, 0, 1'b1, 1'b0, 65535);
    queue_texel(32'h12345678, 2048, 1024, 512, 1'b1, 1'b0, 3000);
    queue_texel(32'h87654321, 1, 2, 4, 1'b0, 1'b0, 65535);
    queue_texel(32'hC0FFEE00, 4094, 2730, 1365, 1'b1, 1'b0, 16);
    for (int i = 0; i < PHASE_ITEMS; i++) queue_random_texel();
    wait_idle();

    // extremes of every register, out-of-range band codes included
    cfg_write_all(32'd0, 32'h8000, 32'd0, 32'h8000, 32'h8000, 32'h8000, 32'd8);
    for (int i = 0; i < PHASE_ITEMS; i++) queue_random_texel();
    wait_idle();
    cfg_write_all(32'hFFFF, 32'h7FFF, 32'hFFFF, 32'h7FFF, 32'h7FFF, 32'h7FFF, 32'd0);
    for (int i = 0; i < PHASE_ITEMS; i++) queue_random_texel();
    wait_idle();
    cfg_write_all(32'hFFFF8000, 32'hFFFF0000, 32'd8192, 32'd0, 32'd0, 32'd0, 32'hF);
    for (int i = 0; i < PHASE_ITEMS; i++) queue_random_texel();
    wait_idle();

    for (int p = 0; p < 11; p++) begin
      cfg_write(REG_LUMA_GAIN, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                            : $urandom_range(0, 32768));
      cfg_write(REG_LUMA_OFFSET, random_shift($urandom_range(0, 3) == 0));
      cfg_write(REG_CHROMA_SCALE, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                               : $urandom_range(0, 16384));
      cfg_write(REG_SHIFT_RED, random_shift($urandom_range(0, 3) == 0));
      cfg_write(REG_SHIFT_GREEN, random_shift($urandom_range(0, 3) == 0));
      cfg_write(REG_SHIFT_BLUE, random_shift($urandom_range(0, 3) == 0));
      cfg_write(REG_BAND_CELLS, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                             : $urandom_range(1, 8));
      for (int i = 0; i < PHASE_ITEMS; i++) queue_random_texel();
      wait_idle();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // sender: bursts of random length separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        loaded.colour    = colour_in_i;
        loaded.red       = ref_red_i;
        loaded.green     = ref_green_i;
        loaded.blue      = ref_blue_i;
        loaded.ref_valid = ref_valid_i;
        loaded.painted   = cell_painted_i;
        loaded.distance  = distance_i;
        expected_blends  = {expected_blends, blend_texel(loaded)};
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (texel_backlog.size() != 0) begin
          loaded = texel_backlog.pop_front();
          colour_in_i    <= loaded.colour;
          ref_red_i      <= loaded.red;
          ref_green_i    <= loaded.green;
          ref_blue_i     <= loaded.blue;
          ref_valid_i    <= loaded.ref_valid;
          cell_painted_i <= loaded.painted;
          distance_i     <= loaded.distance;
          in_valid_i     <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 48);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: check each transfer, stall on a pattern that changes now and then
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_mode  <= 0;
      stall_left  <= 0;
      errors      <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        seen.colour       = colour_out_o;
        seen.filled       = filled_o;
        seen.no_reference = no_reference_o;
        if (expected_blends.size() == 0) begin
          $display("%0t: result with nothing expected: colour %h filled %b no_reference %b",
                   $realtime, seen.colour, seen.filled, seen.no_reference);
          errors <= errors + 1;
        end else begin
          want = expected_blends.pop_front();
          if (seen.colour !== want.colour || seen.filled !== want.filled ||
              seen.no_reference !== want.no_reference) begin
            $display("%0t: mismatch colour exp %h got %h, filled exp %b got %b, %s %b got %b",
                     $realtime, want.colour, seen.colour, want.filled, seen.filled,
                     "no_reference exp", want.no_reference, seen.no_reference);
            errors <= errors + 1;
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(20, 200);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 99) < 30);
        2:       out_stall_i <= ($urandom_range(0, 99) < 70);
        default: out_stall_i <= (cycle_count[2:0] < 3);
      endcase
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_count <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule

@@ filelist.f @@
hdl/tmtb_pkg.sv
hdl/tmtb_weight.sv
hdl/tmtb_tone.sv
hdl/tmtb_blend.sv
hdl/tone_matched_texel_blend.sv
tb/sv/tb.sv
